FILE: rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, switched off while reset is held
`define GFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check on the rising clock that also holds during reset
`define GFBA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/gfba_pkg.sv
// types, constants and command/status structs of the grouped free block allocator
`default_nettype none

package gfba_pkg;

  // geometry
  localparam int GROUP_SIZE = 16;
  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int IDX_W      = $clog2(GROUP_SIZE);
  localparam int DEP_W      = $clog2(GROUP_SIZE + 1);
  localparam int CNT_W      = 11;
  localparam int FUNC_W     = 2;
  localparam int SPILL_AW   = BLK_W + IDX_W;
  localparam int SPILL_WORDS = 2 ** SPILL_AW;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef logic [BLK_W-1:0] blk_num_t;
  typedef logic [IDX_W-1:0] grp_idx_t;
  typedef logic [DEP_W-1:0] depth_t;
  typedef logic [CNT_W-1:0] count_t;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_FORMAT = 2'd0,
    FN_ALLOC  = 2'd1,
    FN_FREE   = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FORMAT,
    ST_RELOAD,
    ST_RELOAD_END,
    ST_SPILL,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic sweep_clr;
    logic fmt_init;
    logic fmt_step;
    logic pop;
    logic fail;
    logic push;
    logic reload_start;
    logic reload_step;
    logic reload_end;
    logic spill_step;
    logic spill_end;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e func;
    logic  stack_low;
    logic  link_end;
    logic  stack_full;
    logic  freed_zero;
    logic  fmt_empty;
    logic  fmt_done;
    logic  sweep_end;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/gfba_dpath.sv
// datapath: current group stack, spill store, format walker and output register
`default_nettype none

module gfba_dpath import gfba_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_stat_t               stat_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire blk_num_t          start_i,
  input  wire count_t            count_i,
  input  wire blk_num_t          freed_i,
  input  wire logic              m_ready_i,
  output logic                   m_valid_o,
  output logic                   m_status_o,
  output blk_num_t               m_granted_o,
  output count_t                 m_used_o
);

  // held operation word
  func_e    func_q;
  blk_num_t start_q;
  count_t   count_q;
  blk_num_t freed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      func_q  <= func_e'(func_i);
      start_q <= start_i;
      count_q <= count_i;
      freed_q <= freed_i;
    end
  end

  // region bounds for format, end clipped to the device
  logic [CNT_W:0] fmt_sum;
  count_t         fmt_end;
  count_t         fmt_first_b;

  always_comb begin
    fmt_sum     = {2'b00, start_q} + {1'b0, count_q};
    fmt_end     = (fmt_sum > (CNT_W+1)'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : fmt_sum[CNT_W-1:0];
    fmt_first_b = {1'b0, start_q} + CNT_W'(1);
  end

  // format walker registers
  count_t   b_q;
  count_t   end_q;
  blk_num_t prevb_q;
  logic     first_q;
  grp_idx_t cnt_q;

  count_t   rem;
  count_t   fmt_bi;
  logic     last;
  depth_t   top;
  logic     grp_end;
  blk_num_t fmt_val;

  always_comb begin
    rem     = end_q - b_q;
    fmt_bi  = b_q + {{(CNT_W-IDX_W){1'b0}}, cnt_q};
    last    = (rem <= CNT_W'(GROUP_SIZE));
    top     = last ? rem[DEP_W-1:0] : DEP_W'(GROUP_SIZE);
    grp_end = ({1'b0, cnt_q} == (top - DEP_W'(1)));
    fmt_val = (cnt_q == '0 && last) ? '0 : fmt_bi[BLK_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fmt_init) begin
      b_q   <= fmt_first_b;
      end_q <= fmt_end;
    end else if (cmd_i.fmt_step && grp_end) begin
      prevb_q <= b_q[BLK_W-1:0];
      b_q     <= b_q + CNT_W'(GROUP_SIZE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (cmd_i.fmt_init) begin
      first_q <= 1'b1;
    end else if (cmd_i.fmt_step && grp_end) begin
      first_q <= 1'b0;
    end
  end

  // sweep counter, shared by format, reload and spill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.fmt_step) begin
      cnt_q <= grp_end ? '0 : cnt_q + IDX_W'(1);
    end else if (cmd_i.reload_step || cmd_i.spill_step) begin
      cnt_q <= cnt_q + IDX_W'(1);
    end
  end

  // current group stack
  blk_num_t stack_q [GROUP_SIZE];
  depth_t   depth_q;
  depth_t   dep_m1;
  grp_idx_t rd_sel;
  blk_num_t stk_rd;

  always_comb begin
    dep_m1 = depth_q - DEP_W'(1);
    rd_sel = cmd_i.spill_step ? cnt_q : dep_m1[IDX_W-1:0];
    stk_rd = stack_q[rd_sel];
  end

  // spill store read side
  blk_num_t rblk_q;
  blk_num_t spill_rd_q;
  depth_t   dep_rd_q;
  grp_idx_t rd_idx_q;
  logic     rd_vld_q;

  // stack write port
  logic     stk_we;
  grp_idx_t stk_wa;
  blk_num_t stk_wd;

  always_comb begin
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = '0;
    if (cmd_i.fmt_init) begin
      stk_we = 1'b1;
    end else if (cmd_i.fmt_step && first_q) begin
      stk_we = 1'b1;
      stk_wa = cnt_q;
      stk_wd = fmt_val;
    end else if (cmd_i.push) begin
      stk_we = 1'b1;
      stk_wa = depth_q[IDX_W-1:0];
      stk_wd = freed_q;
    end else if (rd_vld_q) begin
      stk_we = 1'b1;
      stk_wa = rd_idx_q;
      stk_wd = spill_rd_q;
    end else if (cmd_i.spill_end) begin
      stk_we = 1'b1;
      stk_wd = freed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < GROUP_SIZE; k++) begin
        stack_q[k] <= '0;
      end
    end else if (stk_we) begin
      stack_q[stk_wa] <= stk_wd;
    end
  end

  // reloaded depth, clamped to one..GROUP_SIZE; a stored depth of zero reads as depth one
  depth_t dep_clamp;

  always_comb begin
    if (dep_rd_q == '0) begin
      dep_clamp = DEP_W'(1);
    end else if (dep_rd_q > DEP_W'(GROUP_SIZE)) begin
      dep_clamp = DEP_W'(GROUP_SIZE);
    end else begin
      dep_clamp = dep_rd_q;
    end
  end

  // stack depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEP_W'(1);
    end else if (cmd_i.fmt_init || cmd_i.spill_end) begin
      depth_q <= DEP_W'(1);
    end else if (cmd_i.fmt_step && first_q && cnt_q == '0) begin
      depth_q <= top;
    end else if (cmd_i.pop) begin
      depth_q <= dep_m1;
    end else if (cmd_i.push) begin
      depth_q <= depth_q + DEP_W'(1);
    end else if (cmd_i.reload_end) begin
      depth_q <= dep_clamp;
    end
  end

  // spill store write port
  logic           sp_we;
  logic [SPILL_AW-1:0] sp_wa;
  blk_num_t       sp_wd;
  logic           sd_we;
  blk_num_t       sd_wa;
  depth_t         sd_wd;

  always_comb begin
    sp_we = 1'b0;
    sp_wa = '0;
    sp_wd = '0;
    sd_we = 1'b0;
    sd_wa = '0;
    sd_wd = '0;
    if (cmd_i.spill_step) begin
      sp_we = 1'b1;
      sp_wa = {freed_q, cnt_q};
      sp_wd = stk_rd;
      sd_we = (cnt_q == '0);
      sd_wa = freed_q;
      sd_wd = DEP_W'(GROUP_SIZE);
    end else if (cmd_i.fmt_step && !first_q) begin
      sp_we = 1'b1;
      sp_wa = {prevb_q, cnt_q};
      sp_wd = fmt_val;
      sd_we = (cnt_q == '0);
      sd_wa = prevb_q;
      sd_wd = top;
    end
  end

  // spill store: one entry per block and slot, plus one depth per block
  blk_num_t spill_mem [SPILL_WORDS];
  depth_t   sdep_mem [NUM_BLOCKS];

  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      spill_mem[sp_wa] <= sp_wd;
    end
    spill_rd_q <= spill_mem[{rblk_q, cnt_q}];
  end

  always_ff @(posedge clk_i) begin
    if (sd_we) begin
      sdep_mem[sd_wa] <= sd_wd;
    end
    dep_rd_q <= sdep_mem[rblk_q];
  end

  // reload tracking
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (cmd_i.reload_start) begin
      rblk_q <= stack_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.reload_step;
    end
  end

  // used-block count, saturating both ways
  count_t used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.fmt_init) begin
      used_q <= '0;
    end else if ((cmd_i.pop || cmd_i.reload_start) && used_q != COUNT_MAX) begin
      used_q <= used_q + CNT_W'(1);
    end else if ((cmd_i.push || cmd_i.spill_end) && used_q != '0) begin
      used_q <= used_q - CNT_W'(1);
    end
  end

  // per-operation result
  logic     res_status_q;
  blk_num_t res_granted_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      res_status_q  <= 1'b0;
      res_granted_q <= '0;
    end else if (cmd_i.fail) begin
      res_status_q <= 1'b1;
    end else if (cmd_i.pop) begin
      res_granted_q <= stk_rd;
    end else if (cmd_i.reload_start) begin
      res_granted_q <= stack_q[0];
    end
  end

  // output register
  logic     m_valid_q;
  logic     m_status_q;
  blk_num_t m_granted_q;
  count_t   m_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_status_q  <= res_status_q;
      m_granted_q <= res_granted_q;
      m_used_q    <= used_q;
    end
  end

  assign m_valid_o   = m_valid_q;
  assign m_status_o  = m_status_q;
  assign m_granted_o = m_granted_q;
  assign m_used_o    = m_used_q;

  // status towards the controller
  always_comb begin
    stat_o.func       = func_q;
    stat_o.stack_low  = (depth_q <= DEP_W'(1));
    stat_o.link_end   = (stack_q[0] == '0);
    stat_o.stack_full = (depth_q >= DEP_W'(GROUP_SIZE));
    stat_o.freed_zero = (freed_q == '0);
    stat_o.fmt_empty  = (fmt_first_b >= fmt_end);
    stat_o.fmt_done   = grp_end && last;
    stat_o.sweep_end  = (&cnt_q);
    stat_o.out_free   = !m_valid_q || m_ready_i;
  end

endmodule

`default_nettype wire

FILE: rtl/core/gfba_ctrl.sv
// controller: sequences each operation and the input handshake
`default_nettype none

module gfba_ctrl import gfba_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_valid_i,
  output logic          s_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q;
  state_e state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.sweep_clr = 1'b1;
        state_d         = ST_DONE;
        case (stat_i.func)
          FN_FORMAT: begin
            cmd_o.fmt_init = 1'b1;
            if (!stat_i.fmt_empty) begin
              state_d = ST_FORMAT;
            end
          end
          FN_ALLOC: begin
            if (!stat_i.stack_low) begin
              cmd_o.pop = 1'b1;
            end else if (stat_i.link_end) begin
              cmd_o.fail = 1'b1;
            end else begin
              cmd_o.reload_start = 1'b1;
              state_d            = ST_RELOAD;
            end
          end
          FN_FREE: begin
            if (stat_i.freed_zero) begin
              state_d = ST_DONE;
            end else if (stat_i.stack_full) begin
              state_d = ST_SPILL;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_FORMAT: begin
        cmd_o.fmt_step = 1'b1;
        if (stat_i.fmt_done) begin
          state_d = ST_DONE;
        end
      end
      ST_RELOAD: begin
        cmd_o.reload_step = 1'b1;
        if (stat_i.sweep_end) begin
          state_d = ST_RELOAD_END;
        end
      end
      ST_RELOAD_END: begin
        cmd_o.reload_end = 1'b1;
        state_d          = ST_DONE;
      end
      ST_SPILL: begin
        cmd_o.spill_step = 1'b1;
        if (stat_i.sweep_end) begin
          cmd_o.spill_end = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand the result over, and take the next word in the same cycle
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          s_ready_o      = 1'b1;
          if (s_valid_i) begin
            cmd_o.take_in = 1'b1;
            state_d       = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/grouped_free_block_allocator.sv
// top level of the grouped free block allocator
//
// One operation word in on the slave stream, one result word out on the master
// stream. tuser_i carries the operation: format, allocate, free or no-op.
// Format lays the free list over a block range, allocate pops a block, free
// pushes one back; every word gives exactly one result word.
// A format walks its region one block per cycle. An allocate that reloads the
// next group reads the 16 spilled entries through the spill store read port;
// a free that spills a full group writes 16 entries through the write port.
// A new word is taken in the same cycle as the previous result goes into the
// output register.
// Reset leaves an empty list (stack holds only the end link) and a zero count;
// the spill store is not cleared and needs no clearing pass.
// When the receiver stalls, the result waits in the output register, the next
// word is still taken and worked on, and its result waits until the register
// frees up; no further word is taken meanwhile.
`default_nettype none

module grouped_free_block_allocator import gfba_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // start_block[9:0], block_count[20:10], freed_block[30:21]
  input  wire logic [1:0]  s_axis_tuser_i,  // func[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,  // granted_block[9:0], blocks_in_use[20:10]
  output logic             m_axis_tuser_o   // status[0]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  blk_num_t granted;
  count_t   used;

  // sequencer
  gfba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // stack, spill store and output register
  gfba_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (s_axis_tuser_i),
    .start_i     (s_axis_tdata_i[9:0]),
    .count_i     (s_axis_tdata_i[20:10]),
    .freed_i     (s_axis_tdata_i[30:21]),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_status_o  (m_axis_tuser_o),
    .m_granted_o (granted),
    .m_used_o    (used)
  );

  // result word packing
  assign m_axis_tdata_o = {3'b000, used, granted};

endmodule

`default_nettype wire

FILE: rtl/core/gfba_checker.sv
// port-level checker for the grouped free block allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module gfba_checker import gfba_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_i,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_i,
  input wire logic        m_axis_tuser_i
);

  // a stalled result stays offered
  `GFBA_ASSERT(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i, "result dropped while stalled")

  // a stalled result keeps its word
  `GFBA_ASSERT(a_out_stable, m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i), "result changed while stalled")

  // a failed allocate never hands out a block
  `GFBA_ASSERT(a_fail_no_grant, m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tdata_i[BLK_W-1:0] == '0, "failed allocate carries a block number")

  // nothing is offered on the edge after reset was seen held
  `GFBA_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid_i, "result valid during reset")

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the grouped free block allocator
`default_nettype none

module testbench;
  import gfba_pkg::*;

  localparam int RANDOM_WORDS   = 2000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic     status;
    blk_num_t granted;
    count_t   in_use;
  } alloc_result_t;

  // free list mirror: predicts each result word and checks what comes out
  class free_list_scoreboard;
    depth_t        depth;
    blk_num_t      stack_ent [GROUP_SIZE];
    depth_t        spill_dep [NUM_BLOCKS];
    blk_num_t      spill_ent [NUM_BLOCKS][GROUP_SIZE];
    bit            spill_valid [NUM_BLOCKS];
    blk_num_t      home;
    count_t        in_use;
    blk_num_t      handed_out [$];
    alloc_result_t pending [$];
    int            errors;

    function new();
      foreach (spill_dep[i]) spill_dep[i] = '0;
      foreach (spill_ent[i, j]) spill_ent[i][j] = '0;
      foreach (spill_valid[i]) spill_valid[i] = 1'b0;
      clear_stack();
      home   = '0;
      in_use = '0;
      errors = 0;
    endfunction

    function void clear_stack();
      depth = 1;
      foreach (stack_ent[i]) stack_ent[i] = '0;
    endfunction

    // false when an allocate would reload a group that was never stored
    function bit reload_safe();
      return depth > 1 || stack_ent[0] == '0 || spill_valid[stack_ent[0]];
    endfunction

    // lay groups over the region; the last group's link slot is lost
    function void format_region(blk_num_t start, count_t cnt);
      int unsigned region_end, dest, b, rem, top;
      bit          first, last;
      blk_num_t    grp [GROUP_SIZE];
      region_end = start + cnt;
      if (region_end > NUM_BLOCKS) region_end = NUM_BLOCKS;
      clear_stack();
      home   = start;
      in_use = '0;
      handed_out.delete();
      dest   = start;
      first  = 1'b1;
      for (b = start + 1; b < region_end; b += GROUP_SIZE) begin
        rem  = region_end - b;
        last = rem <= GROUP_SIZE;
        top  = last ? rem : GROUP_SIZE;
        foreach (grp[i]) grp[i] = (i < top) ? blk_num_t'(b + i) : '0;
        if (last) grp[0] = '0;
        if (first) begin
          depth     = depth_t'(top);
          stack_ent = grp;
        end else if (dest < NUM_BLOCKS) begin
          spill_dep[dest]   = depth_t'(top);
          spill_ent[dest]   = grp;
          spill_valid[dest] = 1'b1;
        end
        first = 1'b0;
        dest  = grp[0];
      end
    endfunction

    // pop a block, or hand out the link and load its group
    function alloc_result_t alloc_block();
      alloc_result_t r;
      blk_num_t      nxt;
      r.status  = 1'b0;
      r.granted = '0;
      r.in_use  = in_use;
      if (depth <= 1) begin
        nxt = stack_ent[0];
        if (nxt == '0) begin
          r.status = 1'b1;
          return r;
        end
        r.granted = nxt;
        depth     = spill_dep[nxt];
        if (depth == 0) depth = 1;
        if (depth > GROUP_SIZE) depth = GROUP_SIZE;
        stack_ent = spill_ent[nxt];
      end else begin
        depth--;
        r.granted = stack_ent[depth[IDX_W-1:0]];
      end
      if (in_use != '1) in_use++;
      handed_out.push_back(r.granted);
      return r;
    endfunction

    // push a block, spilling a full stack into it first
    function void push_block(blk_num_t blk);
      if (blk == '0) return;
      if (depth >= GROUP_SIZE) begin
        spill_dep[blk]   = depth_t'(GROUP_SIZE);
        spill_ent[blk]   = stack_ent;
        spill_valid[blk] = 1'b1;
        depth            = 1;
        stack_ent[0]     = blk;
      end else begin
        stack_ent[depth[IDX_W-1:0]] = blk;
        depth++;
      end
      if (in_use != '0) in_use--;
    endfunction

    function void note_request(func_e f, blk_num_t start, count_t cnt, blk_num_t freed);
      alloc_result_t r;
      r.status  = 1'b0;
      r.granted = '0;
      case (f)
        FN_FORMAT: format_region(start, cnt);
        FN_ALLOC:  r = alloc_block();
        FN_FREE:   push_block(freed);
        default: ;
      endcase
      r.in_use = in_use;
      pending.push_back(r);
    endfunction

    function void check_result(logic status, blk_num_t granted, count_t in_use_o);
      alloc_result_t want;
      if (pending.size() == 0) begin
        $error("result word arrived with none outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (granted !== want.granted) begin
        $error("granted_block: expected %0d, got %0d", want.granted, granted);
        errors++;
      end
      if (in_use_o !== want.in_use) begin
        $error("blocks_in_use: expected %0d, got %0d", want.in_use, in_use_o);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  int tx_idle_pct = 32;
  int rx_idle_pct = 32;
  int words_in    = 0;
  int idle_cycles = 0;

  free_list_scoreboard sb = new();

  always #10 clk_i = ~clk_i;

  grouped_free_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // both handshakes sampled on the rising edge, plus the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        sb.note_request(func_e'(s_tuser), s_tdata[9:0], s_tdata[20:10], s_tdata[30:21]);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tuser, m_tdata[9:0], m_tdata[20:10]);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // present one word after a random gap and hold it until taken
  task automatic send_word(func_e f, blk_num_t start, count_t cnt, blk_num_t freed);
    int seen;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {1'b0, freed, cnt, start};
    seen = words_in;
    do @(negedge clk_i); while (words_in == seen);
  endtask

  // mostly alloc/free traffic on the live list, some formats and noise
  task automatic pick_word(input int mode, output func_e f, output blk_num_t start,
                           output count_t cnt, output blk_num_t freed);
    int roll;
    int alloc_pct;
    int idx;
    f     = FN_NOP;
    start = blk_num_t'($urandom);
    cnt   = count_t'($urandom);
    freed = blk_num_t'($urandom);
    roll  = $urandom_range(99);
    if (roll < 3) begin
      case ($urandom_range(2))
        0: f = FN_NOP;
        1: begin
          f     = FN_FREE;
          freed = '0;
        end
        default: f = FN_FREE;
      endcase
    end else if (roll < 5) begin
      f = FN_FORMAT;
      case ($urandom_range(9))
        8:       cnt = count_t'(NUM_BLOCKS - start);
        9:       cnt = count_t'($urandom_range(0, 2047));
        default: cnt = count_t'($urandom_range(0, 80));
      endcase
    end else begin
      alloc_pct = (mode == 0) ? 85 : (mode == 1) ? 12 : 50;
      if ($urandom_range(99) < alloc_pct && sb.reload_safe()) begin
        f = FN_ALLOC;
      end else begin
        f = FN_FREE;
        if (sb.handed_out.size() > 0) begin
          idx   = $urandom_range(sb.handed_out.size() - 1);
          freed = sb.handed_out[idx];
          sb.handed_out.delete(idx);
        end else begin
          freed = blk_num_t'($urandom_range(1, NUM_BLOCKS - 1));
        end
      end
    end
  endtask

  initial begin
    func_e    f;
    blk_num_t start;
    count_t   cnt;
    blk_num_t freed;
    int       counted;
    int       mode;
    int       mode_left;

    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = FN_NOP;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list, bad free, field extremes, short and clipped regions
    send_word(FN_ALLOC,  '0,        '0,         '0);
    send_word(FN_FREE,   '0,        '0,         '0);
    send_word(FN_FREE,   '0,        '0,         10'd1023);
    send_word(FN_ALLOC,  '0,        '0,         '0);
    send_word(FN_NOP,    10'd1023,  11'd2047,   10'd1023);
    send_word(FN_FORMAT, 10'd1023,  11'd2047,   '0);
    send_word(FN_FORMAT, '0,        '0,         '0);
    send_word(FN_ALLOC,  '0,        '0,         '0);
    send_word(FN_FORMAT, '0,        11'd1,      '0);
    send_word(FN_FORMAT, '0,        11'd2,      '0);
    // two groups: drain the stack, reload through the link, then run dry
    send_word(FN_FORMAT, 10'd5,     11'd18,     '0);
    repeat (18) send_word(FN_ALLOC, '0, '0, '0);

    // random traffic in alloc-heavy, free-heavy and balanced spells
    counted   = 0;
    mode      = 2;
    mode_left = 0;
    while (counted < RANDOM_WORDS) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      if (counted >= 800 && counted < 1100) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 32;
        rx_idle_pct = 32;
      end
      pick_word(mode, f, start, cnt, freed);
      send_word(f, start, cnt, freed);
      if (!(f == FN_NOP || (f == FN_FREE && freed == '0))) counted++;
    end
    s_tvalid <= 1'b0;

    // wait for outstanding results, then watch for strays
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/gfba_pkg.sv
rtl/core/gfba_dpath.sv
rtl/core/gfba_ctrl.sv
rtl/core/grouped_free_block_allocator.sv
rtl/core/gfba_checker.sv
tb/sv/testbench.sv
